// File: design/swm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and types for the sliding window median unit.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int IDX_W       = $clog2(MAX_WINDOW);
  localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
  localparam int CFG_W       = 7;
  localparam int RESET_LEN   = 3;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  // Raw contents of one cell.
  typedef struct packed {
    logic    valid;
    sample_t value;
  } cell_t;

  // Link from a cell to its upper neighbour: state after the removal step,
  // and whether that entry sorts above the incoming sample.
  typedef struct packed {
    logic    gt;
    logic    valid;
    sample_t value;
  } link_t;

  // Controls broadcast along the whole chain.
  typedef struct packed {
    logic    clr;
    logic    ins;
    logic    del;
    sample_t sample;
    sample_t old;
  } bcast_t;

endpackage

// File: design/sliding_window_median_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_unit
// Lower median over the last window_length samples, kept in a sorted chain
// of cells with an arrival-order ring beside it.
// ----------------------------------------------------------------------------
// channel   | dir | handshake                | payload
// s_axis    | in  | s_axis_tvalid/tready     | tdata[15:0] sample
// m_axis    | out | m_axis_tvalid/tready     | tdata[15:0] median
// cfg       | in  | cfg_wr_en                | cfg_wr_data[6:0] window_length
//
// One item per cycle while s_axis_tready is high: the cells drop the oldest
// entry and insert the new one at the edge that takes the item; a full window
// sets pend, and the median tap loads m_axis once the output register is free.
// Synchronous reset empties the window and sets the length to 3.
// A length write also empties the window. s_axis stalls only while a median
// waits in the tap stage and the output register is held.
// ----------------------------------------------------------------------------
module sliding_window_median_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] median
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data
);

  localparam int N  = swm_pkg::MAX_WINDOW;
  localparam int IW = swm_pkg::IDX_W;
  localparam int CW = swm_pkg::CNT_W;

  logic [swm_pkg::CFG_W-1:0] window_length;
  logic [CW-1:0]             k;
  logic [IW-1:0]             med_idx;
  logic [CW-1:0]             fill_count;
  logic [CW-1:0]             fill_count_next;
  logic [IW-1:0]             ring_pointer;
  logic [IW-1:0]             ring_pointer_next;
  logic [CW-1:0]             rp_inc;
  logic [IW-1:0]             rd_addr;
  swm_pkg::sample_t          ram_rdata;
  swm_pkg::sample_t          byp_data;
  logic                      byp;
  logic                      accept;
  logic                      full;
  logic                      pend;
  logic                      out_free;
  swm_pkg::bcast_t           ctl;
  swm_pkg::cell_t            raw  [N+1];
  swm_pkg::link_t            link [N+1];
  logic [N-1:0]              valid_vec;

  // effective window length, clamped to 1..N
  always_comb begin
    if (window_length == '0) begin
      k = CW'(1);
    end else if (CW'(window_length) > CW'(N)) begin
      k = CW'(N);
    end else begin
      k = CW'(window_length);
    end
  end

  assign med_idx  = IW'((k - CW'(1)) >> 1);
  assign full     = (fill_count == k);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !pend || out_free;
  assign accept   = s_axis_tvalid && s_axis_tready;

  assign rp_inc = CW'(ring_pointer) + CW'(1);
  always_comb begin
    ring_pointer_next = ring_pointer;
    fill_count_next   = fill_count;
    if (accept) begin
      ring_pointer_next = (rp_inc >= k) ? '0 : IW'(rp_inc);
      if (!full) begin
        fill_count_next = fill_count + CW'(1);
      end
    end
  end

  // keep the read port aimed at the oldest slot
  assign rd_addr = cfg_wr_en ? '0 : ring_pointer_next;

  swm_ram #(
    .WIDTH (swm_pkg::SAMPLE_BITS),
    .DEPTH (N)
  ) u_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (ring_pointer),
    .wdata (s_axis_tdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // read of the slot being written this cycle (window of one)
  always_ff @(posedge clk) begin
    byp      <= accept && (rd_addr == ring_pointer);
    byp_data <= s_axis_tdata;
  end

  always_comb begin
    ctl.clr    = cfg_wr_en;
    ctl.ins    = accept;
    ctl.del    = accept && full;
    ctl.sample = s_axis_tdata;
    ctl.old    = byp ? byp_data : ram_rdata;
  end

  assign raw[N]  = '0;
  assign link[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    swm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .up_raw  (raw[i+1]),
      .dn_link (link[i]),
      .raw     (raw[i]),
      .link    (link[i+1])
    );
    assign valid_vec[i] = raw[i].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= swm_pkg::CFG_W'(swm_pkg::RESET_LEN);
      fill_count    <= '0;
      ring_pointer  <= '0;
      pend          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_length <= cfg_wr_data;
        fill_count    <= '0;
        ring_pointer  <= '0;
      end else begin
        fill_count    <= fill_count_next;
        ring_pointer  <= ring_pointer_next;
      end
      if (accept && (fill_count_next == k)) begin
        pend <= 1'b1;
      end else if (out_free) begin
        pend <= 1'b0;
      end
      if (out_free) begin
        m_axis_tvalid <= pend;
      end
    end
  end

  // median tap reads the chain as left by the item that set pend
  always_ff @(posedge clk) begin
    if (out_free && pend) begin
      m_axis_tdata <= raw[CW'(med_idx)].value;
    end
  end

`ifndef ASSERT_OFF
  a_fill_le_k : assert property (@(posedge clk) disable iff (rst)
    fill_count <= k)
    else $error("fill count above window length");

  a_ptr_lt_k : assert property (@(posedge clk) disable iff (rst)
    CW'(ring_pointer) < k)
    else $error("ring pointer outside window");

  a_cells_match_fill : assert property (@(posedge clk) disable iff (rst)
    CW'($countones(valid_vec)) == fill_count)
    else $error("occupied cells disagree with fill count");

  a_median_valid : assert property (@(posedge clk) disable iff (rst)
    (pend && out_free) |-> raw[CW'(med_idx)].valid)
    else $error("median tap on an empty cell");
`endif

endmodule

// File: design/swm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module swm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/swm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted chain: removes the outgoing entry by pulling from
// above, then makes room for the new sample by pushing upwards.
// ----------------------------------------------------------------------------
module swm_cell (
  input  logic           clk,
  input  logic           rst,
  input  swm_pkg::bcast_t ctl,
  input  swm_pkg::cell_t  up_raw,   // raw state of the cell above
  input  swm_pkg::link_t  dn_link,  // post-removal state of the cell below
  output swm_pkg::cell_t  raw,
  output swm_pkg::link_t  link
);

  swm_pkg::cell_t st;
  swm_pkg::cell_t st_next;
  logic           pull;

  // Empty slots sort as infinity, so they always pull and always push.
  always_comb begin
    pull       = ctl.del && (!st.valid || st.value >= ctl.old);
    link.valid = pull ? up_raw.valid : st.valid;
    link.value = pull ? up_raw.value : st.value;
    link.gt    = !link.valid || link.value > ctl.sample;

    st_next = st;
    if (ctl.ins) begin
      if (!link.gt) begin
        st_next.valid = link.valid;
        st_next.value = link.value;
      end else if (dn_link.gt) begin
        st_next.valid = dn_link.valid;
        st_next.value = dn_link.value;
      end else begin
        st_next.valid = 1'b1;
        st_next.value = ctl.sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      st.valid <= 1'b0;
    end else begin
      st.valid <= st_next.valid;
    end
    st.value <= st_next.value;
  end

  assign raw = st;

endmodule
